>>> sv/sirc_pkg.sv
// Shared types and constants for the SIRC 12-bit run decoder.
// No dependencies; every other file imports this package.
package sirc_pkg;

  // Run and result field widths
  localparam int RUN_LEN_W = 16;
  localparam int STATUS_W  = 3;
  localparam int CMD_OUT_W = 7;
  localparam int ADR_OUT_W = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int LEN_CFG_W  = 8;
  localparam int TOL_W      = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MARK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_SPACE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd5;

  // Register reset values
  localparam logic [LEN_CFG_W-1:0] RST_LEADER_MARK  = 8'd91;
  localparam logic [LEN_CFG_W-1:0] RST_LEADER_SPACE = 8'd23;
  localparam logic [LEN_CFG_W-1:0] RST_ZERO_MARK    = 8'd23;
  localparam logic [LEN_CFG_W-1:0] RST_ONE_MARK     = 8'd46;
  localparam logic [LEN_CFG_W-1:0] RST_BIT_SPACE    = 8'd23;
  localparam logic [TOL_W-1:0]     RST_TOLERANCE    = 6'd4;

  // Queue between classifier and frame tracker
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    PH_LEAD_MARK  = 2'd0,
    PH_LEAD_SPACE = 2'd1,
    PH_BIT_MARK   = 2'd2,
    PH_BIT_SPACE  = 2'd3
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_BAD_LEAD_MARK  = 3'd1,
    ST_BAD_LEAD_SPACE = 3'd2,
    ST_BAD_BIT_MARK   = 3'd3,
    ST_BAD_BIT_SPACE  = 3'd4
  } status_e;

  // Window verdicts of one run; every flag but space_hi_ok already includes the level check
  typedef struct packed {
    logic lead_mark_ok;
    logic lead_space_ok;
    logic zero_ok;
    logic one_ok;
    logic space_lo_ok;
    logic space_hi_ok;
  } run_class_t;

endpackage

>>> sv/sirc_ifs.sv
// Handshake channel interfaces: runs in, results out, configuration writes.
// Depends on sirc_pkg for field widths.
interface sirc_run_if
  import sirc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 run_level;
  logic [RUN_LEN_W-1:0] run_length;

  modport source (output valid, output run_level, output run_length, input ready);
  modport sink   (input valid, input run_level, input run_length, output ready);
endinterface

interface sirc_res_if
  import sirc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CMD_OUT_W-1:0] command;
  logic [ADR_OUT_W-1:0] address;

  modport source (output valid, output status, output command, output address, input ready);
  modport sink   (input valid, input status, input command, input address, output ready);
endinterface

interface sirc_cfg_if
  import sirc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/sirc_front.sv
// Front end: configuration registers and window classification of each run.
// Depends on sirc_pkg and sirc_ifs; pushes verdicts into sirc_queue.
module sirc_front
  import sirc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sirc_run_if.sink    run,
  sirc_cfg_if.sink    cfg,
  input  logic        q_ready_i,
  output logic        q_push_o,
  output run_class_t  q_data_o
);

  localparam int CMP_W = RUN_LEN_W + 1;

  logic [LEN_CFG_W-1:0] leader_mark_q, leader_space_q, zero_mark_q, one_mark_q, bit_space_q;
  logic [TOL_W-1:0]     tolerance_q;
  logic [CMP_W-1:0]     len_ext, len_lo, tol_ext;

  // Registers are to be written only while the block is idle; the block does not enforce it, ready stays high
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leader_mark_q  <= RST_LEADER_MARK;
      leader_space_q <= RST_LEADER_SPACE;
      zero_mark_q    <= RST_ZERO_MARK;
      one_mark_q     <= RST_ONE_MARK;
      bit_space_q    <= RST_BIT_SPACE;
      tolerance_q    <= RST_TOLERANCE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LEADER_MARK:  leader_mark_q  <= cfg.data;
        REG_LEADER_SPACE: leader_space_q <= cfg.data;
        REG_ZERO_MARK:    zero_mark_q    <= cfg.data;
        REG_ONE_MARK:     one_mark_q     <= cfg.data;
        REG_BIT_SPACE:    bit_space_q    <= cfg.data;
        REG_TOLERANCE:    tolerance_q    <= cfg.data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare len against nom -/+ tol without going negative: len + tol vs nom
  assign len_ext = CMP_W'(run.run_length);
  assign tol_ext = CMP_W'(tolerance_q);
  assign len_lo  = len_ext + tol_ext;

  function automatic logic above_lo(input logic [CMP_W-1:0] lo_sum,
                                    input logic [LEN_CFG_W-1:0] nom,
                                    input logic strict);
    logic [CMP_W-1:0] nom_ext;
    nom_ext = CMP_W'(nom);
    return strict ? (lo_sum > nom_ext) : (lo_sum >= nom_ext);
  endfunction

  function automatic logic below_hi(input logic [CMP_W-1:0] len_v,
                                    input logic [LEN_CFG_W-1:0] nom,
                                    input logic [CMP_W-1:0] tol_v,
                                    input logic strict);
    logic [CMP_W-1:0] hi;
    hi = CMP_W'(nom) + tol_v;
    return strict ? (len_v < hi) : (len_v <= hi);
  endfunction

  // Classify the run against every window; level folded in, except for space_hi_ok
  always_comb begin
    q_data_o.lead_mark_ok  = !run.run_level
                           && above_lo(len_lo, leader_mark_q, 1'b0)
                           && below_hi(len_ext, leader_mark_q, tol_ext, 1'b0);
    q_data_o.lead_space_ok = run.run_level
                           && above_lo(len_lo, leader_space_q, 1'b0)
                           && below_hi(len_ext, leader_space_q, tol_ext, 1'b0);
    q_data_o.zero_ok       = !run.run_level
                           && above_lo(len_lo, zero_mark_q, 1'b1)
                           && below_hi(len_ext, zero_mark_q, tol_ext, 1'b1);
    q_data_o.one_ok        = !run.run_level
                           && above_lo(len_lo, one_mark_q, 1'b1)
                           && below_hi(len_ext, one_mark_q, tol_ext, 1'b1);
    q_data_o.space_lo_ok   = run.run_level && above_lo(len_lo, bit_space_q, 1'b0);
    q_data_o.space_hi_ok   = below_hi(len_ext, bit_space_q, tol_ext, 1'b0);
  end

  // Transfer a run whenever the queue has room
  assign run.ready = q_ready_i;
  assign q_push_o  = run.valid && q_ready_i;

endmodule

>>> sv/sirc_queue.sv
// Two-entry register queue of run verdicts between front and back end.
// Depends on sirc_pkg for run_class_t and queue sizing.
module sirc_queue
  import sirc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  run_class_t push_data_i,
  output logic       push_ready_o,
  input  logic       pop_i,
  output logic       pop_valid_o,
  output run_class_t pop_data_o
);

  run_class_t         entries_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q;

  assign push_ready_o = (count_q != Q_CNT_W'(Q_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + Q_CNT_W'(1);
        2'b01:   count_q <= count_q - Q_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> sv/sirc_back.sv
// Back end: frame state machine over classified runs, plus result register.
// Depends on sirc_pkg and sirc_ifs; reads verdicts from sirc_queue.
module sirc_back
  import sirc_pkg::*;
#(
  parameter int COMMAND_BITS = 7,
  parameter int ADDRESS_BITS = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  run_class_t q_data_i,
  output logic       q_pop_o,
  sirc_res_if.source res
);

  localparam int TOTAL_BITS = COMMAND_BITS + ADDRESS_BITS;
  localparam int CNT_W      = $clog2(TOTAL_BITS);
  localparam int CMD_EXT_W  = COMMAND_BITS + CMD_OUT_W;
  localparam int ADR_EXT_W  = ADDRESS_BITS + ADR_OUT_W;

  phase_e                phase_q, phase_d;
  logic [CNT_W-1:0]      bit_cnt_q, bit_cnt_d;
  logic [TOTAL_BITS-1:0] frame_q, frame_d;

  logic                  last_bit;
  logic                  space_ok;
  logic                  emit;
  status_e               emit_status;
  logic                  out_free;
  logic                  out_load;

  logic                  out_valid_q;
  status_e               status_q;
  logic [CMD_OUT_W-1:0]  command_q;
  logic [ADR_OUT_W-1:0]  address_q;
  logic [CMD_EXT_W-1:0]  cmd_ext;
  logic [ADR_EXT_W-1:0]  adr_ext;

  assign last_bit = (bit_cnt_q == CNT_W'(TOTAL_BITS - 1));
  assign space_ok = q_data_i.space_lo_ok && (last_bit || q_data_i.space_hi_ok);

  // Next phase
  always_comb begin
    phase_d = PH_LEAD_MARK;
    case (phase_q)
      PH_LEAD_MARK:  phase_d = q_data_i.lead_mark_ok ? PH_LEAD_SPACE : PH_LEAD_MARK;
      PH_LEAD_SPACE: phase_d = q_data_i.lead_space_ok ? PH_BIT_MARK : PH_LEAD_MARK;
      PH_BIT_MARK:   phase_d = (q_data_i.zero_ok || q_data_i.one_ok) ? PH_BIT_SPACE
                                                                     : PH_LEAD_MARK;
      PH_BIT_SPACE:  phase_d = (space_ok && !last_bit) ? PH_BIT_MARK : PH_LEAD_MARK;
      default:       phase_d = PH_LEAD_MARK;
    endcase
  end

  // Result decision and frame datapath
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    bit_cnt_d   = bit_cnt_q;
    frame_d     = frame_q;
    case (phase_q)
      PH_LEAD_MARK: begin
        emit        = !q_data_i.lead_mark_ok;
        emit_status = ST_BAD_LEAD_MARK;
      end
      PH_LEAD_SPACE: begin
        emit        = !q_data_i.lead_space_ok;
        emit_status = ST_BAD_LEAD_SPACE;
      end
      PH_BIT_MARK: begin
        emit        = !(q_data_i.zero_ok || q_data_i.one_ok);
        emit_status = ST_BAD_BIT_MARK;
        // The zero window wins where both hold
        if (!q_data_i.zero_ok && q_data_i.one_ok) begin
          frame_d[bit_cnt_q] = 1'b1;
        end
      end
      PH_BIT_SPACE: begin
        emit        = !space_ok || last_bit;
        emit_status = space_ok ? ST_OK : ST_BAD_BIT_SPACE;
        bit_cnt_d   = bit_cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
    // Any result, and a good leader space, start the frame afresh
    if (emit || phase_q == PH_LEAD_SPACE) begin
      bit_cnt_d = '0;
      frame_d   = '0;
    end
  end

  // Drop a verdict only when its result, if any, has a place to go
  assign out_free = !out_valid_q || res.ready;
  assign q_pop_o  = q_valid_i && (!emit || out_free);
  assign out_load = q_pop_o && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEAD_MARK;
      bit_cnt_q <= '0;
      frame_q   <= '0;
    end else if (q_pop_o) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      frame_q   <= frame_d;
    end
  end

  // Split the frame into command and address, sized to the output fields
  assign cmd_ext = CMD_EXT_W'(frame_q[COMMAND_BITS-1:0]);
  assign adr_ext = ADR_EXT_W'(frame_q[TOTAL_BITS-1:COMMAND_BITS]);

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= emit_status;
      command_q <= (emit_status == ST_OK) ? cmd_ext[CMD_OUT_W-1:0] : '0;
      address_q <= (emit_status == ST_OK) ? adr_ext[ADR_OUT_W-1:0] : '0;
    end
  end

  assign res.valid   = out_valid_q;
  assign res.status  = status_q;
  assign res.command = command_q;
  assign res.address = address_q;

  // Outside the data-bit phases the frame is empty
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEAD_MARK || phase_q == PH_LEAD_SPACE) |-> (frame_q == '0 && bit_cnt_q == '0))
    else $error("frame state not cleared outside data phases");

  // Bit counter never passes the last data bit
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= CNT_W'(TOTAL_BITS - 1))
    else $error("bit counter out of range");

  // Every result sends the tracker back to the leader mark
  a_emit_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (phase_q == PH_LEAD_MARK && bit_cnt_q == '0))
    else $error("tracker did not restart after a result");

  // A good frame is only loaded from the last bit space
  a_ok_from_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && emit_status == ST_OK) |-> (phase_q == PH_BIT_SPACE && last_bit))
    else $error("frame reported good outside the final bit space");

endmodule

>>> sv/ir_sirc12_run_decoder_top.sv
// SIRC 12-bit run decoder. Each transfer on run_i is one run of constant level
// (0 mark, 1 space) with its length in carrier cycles; the block checks leader
// mark, leader space and COMMAND_BITS + ADDRESS_BITS data bits (LSB first) and
// sends one result on res_o per completed frame or per bad run. A run is taken
// every clock cycle while the two-entry queue behind the classifier has room;
// the frame state machine retires one queued run per cycle, stalling only when
// a run produces a result while the output register still holds an untaken
// one. With the queue empty and the output register free, a run's result passes
// through the queue entry and then the output register to become valid on res_o.
// Write the six window registers on cfg_i only while no frame is in flight.
// Depends on sirc_pkg, sirc_ifs, sirc_front, sirc_queue and sirc_back.
module ir_sirc12_run_decoder_top
  import sirc_pkg::*;
#(
  parameter int COMMAND_BITS = 7,
  parameter int ADDRESS_BITS = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sirc_run_if.sink   run_i,
  sirc_cfg_if.sink   cfg_i,
  sirc_res_if.source res_o
);

  logic       push;
  logic       push_ready;
  run_class_t push_data;
  logic       pop;
  logic       pop_valid;
  run_class_t pop_data;

  sirc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .run       (run_i),
    .cfg       (cfg_i),
    .q_ready_i (push_ready),
    .q_push_o  (push),
    .q_data_o  (push_data)
  );

  sirc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  sirc_back #(
    .COMMAND_BITS (COMMAND_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_data_i  (pop_data),
    .q_pop_o   (pop),
    .res       (res_o)
  );

endmodule

>>> dv/ir_sirc12_run_decoder_top_test.sv
// Self-checking testbench for ir_sirc12_run_decoder_top: drives runs, window registers
// and result backpressure, and compares every result with a frame predictor.
// Depends on sirc_pkg, sirc_ifs and the decoder RTL.
`timescale 1ns / 100ps

module ir_sirc12_run_decoder_top_test;
  import sirc_pkg::*;

  localparam int CMD_BITS     = 7;
  localparam int ADR_BITS     = 5;
  localparam int TOTAL_BITS   = CMD_BITS + ADR_BITS;
  localparam int FRAME_RUNS   = 2 + 2 * TOTAL_BITS;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 210;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    status_e              status;
    logic [CMD_OUT_W-1:0] command;
    logic [ADR_OUT_W-1:0] address;
  } sirc_result_t;

  // Frame predictor: window registers, frame state and the results still owed
  class sirc_frame_tracker;
    logic [LEN_CFG_W-1:0] lead_mark_len;
    logic [LEN_CFG_W-1:0] lead_space_len;
    logic [LEN_CFG_W-1:0] zero_mark_len;
    logic [LEN_CFG_W-1:0] one_mark_len;
    logic [LEN_CFG_W-1:0] bit_space_len;
    logic [TOL_W-1:0]     tolerance;
    phase_e               phase;
    int                   bit_count;
    logic [TOTAL_BITS-1:0] frame_bits;
    sirc_result_t         owed_results[$];
    int                   errors;

    function new();
      lead_mark_len  = RST_LEADER_MARK;
      lead_space_len = RST_LEADER_SPACE;
      zero_mark_len  = RST_ZERO_MARK;
      one_mark_len   = RST_ONE_MARK;
      bit_space_len  = RST_BIT_SPACE;
      tolerance      = RST_TOLERANCE;
      phase          = PH_LEAD_MARK;
      bit_count      = 0;
      frame_bits     = '0;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LEADER_MARK:  lead_mark_len  = val;
        REG_LEADER_SPACE: lead_space_len = val;
        REG_ZERO_MARK:    zero_mark_len  = val;
        REG_ONE_MARK:     one_mark_len   = val;
        REG_BIT_SPACE:    bit_space_len  = val;
        REG_TOLERANCE:    tolerance      = val[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    // Inclusive window; a negative lower bound lets every length pass it
    function bit closed_hit(int len, int nom);
      int lo = nom - int'(tolerance);
      int hi = nom + int'(tolerance);
      return len >= lo && len <= hi;
    endfunction

    // Exclusive window used for bit marks
    function bit open_hit(int len, int nom);
      int lo = nom - int'(tolerance);
      int hi = nom + int'(tolerance);
      return len > lo && len < hi;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Queue one result and go back to waiting for a leader mark
    function void emit(status_e st, logic [CMD_OUT_W-1:0] cmd, logic [ADR_OUT_W-1:0] adr);
      sirc_result_t r;
      r.status  = st;
      r.command = cmd;
      r.address = adr;
      owed_results.push_back(r);
      phase      = PH_LEAD_MARK;
      bit_count  = 0;
      frame_bits = '0;
    endfunction

    // Advance the frame state by one accepted run
    function void note_run(logic lvl, logic [RUN_LEN_W-1:0] len_v);
      int len;
      int lo;
      int hi;
      bit last;
      len = int'(len_v);
      case (phase)
        PH_LEAD_MARK: begin
          if (lvl != 1'b0 || !closed_hit(len, int'(lead_mark_len)))
            emit(ST_BAD_LEAD_MARK, '0, '0);
          else phase = PH_LEAD_SPACE;
        end
        PH_LEAD_SPACE: begin
          if (lvl != 1'b1 || !closed_hit(len, int'(lead_space_len))) begin
            emit(ST_BAD_LEAD_SPACE, '0, '0);
          end else begin
            bit_count  = 0;
            frame_bits = '0;
            phase      = PH_BIT_MARK;
          end
        end
        PH_BIT_MARK: begin
          // zero test wins where both windows hold
          if (lvl != 1'b0) begin
            emit(ST_BAD_BIT_MARK, '0, '0);
          end else if (open_hit(len, int'(zero_mark_len))) begin
            phase = PH_BIT_SPACE;
          end else if (open_hit(len, int'(one_mark_len))) begin
            frame_bits[bit_count] = 1'b1;
            phase = PH_BIT_SPACE;
          end else begin
            emit(ST_BAD_BIT_MARK, '0, '0);
          end
        end
        default: begin
          // the space after the last bit has no upper bound
          last = (bit_count + 1) >= TOTAL_BITS;
          lo   = int'(bit_space_len) - int'(tolerance);
          hi   = int'(bit_space_len) + int'(tolerance);
          if (lvl != 1'b1 || len < lo || (!last && len > hi)) begin
            emit(ST_BAD_BIT_SPACE, '0, '0);
          end else if (last) begin
            emit(ST_OK, frame_bits[CMD_BITS-1:0], frame_bits[CMD_BITS +: ADR_BITS]);
          end else begin
            bit_count++;
            phase = PH_BIT_MARK;
          end
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    endtask

    // Compare one transferred result with the oldest owed one
    task check_result(logic [STATUS_W-1:0] st, logic [CMD_OUT_W-1:0] cmd,
                      logic [ADR_OUT_W-1:0] adr);
      sirc_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result status %0d with none owed", st));
      end else begin
        want = owed_results.pop_front();
        if (st !== want.status)
          report($sformatf("status %0d, want %0d", st, want.status));
        if (cmd !== want.command)
          report($sformatf("command %0h, want %0h", cmd, want.command));
        if (adr !== want.address)
          report($sformatf("address %0h, want %0h", adr, want.address));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sirc_run_if run_if ();
  sirc_cfg_if cfg_if ();
  sirc_res_if res_if ();

  ir_sirc12_run_decoder_top #(
    .COMMAND_BITS(CMD_BITS),
    .ADDRESS_BITS(ADR_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .run_i (run_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  sirc_frame_tracker tracker;
  int items_sent  = 0;
  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;
  int sink_hold   = 0;

  always #10 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Random length within a window, clamped at zero
  function automatic int draw_len(int nom, int tol, bit strict);
    int lo = nom - tol + (strict ? 1 : 0);
    int hi = nom + tol - (strict ? 1 : 0);
    if (lo < 0) lo = 0;
    if (hi < lo) return nom;
    return $urandom_range(hi, lo);
  endfunction

  // Length near some window edge, small, or anywhere in range
  function automatic int noise_len();
    int nom;
    int tol;
    int v;
    tol = int'(tracker.tolerance);
    case ($urandom_range(4))
      0: nom = int'(tracker.lead_mark_len);
      1: nom = int'(tracker.lead_space_len);
      2: nom = int'(tracker.zero_mark_len);
      3: nom = int'(tracker.one_mark_len);
      default: nom = int'(tracker.bit_space_len);
    endcase
    case ($urandom_range(3))
      0: return $urandom_range(65535);
      1: return $urandom_range(300);
      default: begin
        v = nom - tol - 3 + $urandom_range(2 * tol + 6);
        return (v < 0) ? 0 : v;
      end
    endcase
  endfunction

  // Offer one run, hold it until the transfer, then maybe idle
  task automatic send_run(logic lvl, logic [RUN_LEN_W-1:0] len);
    int gap;
    run_if.valid      <= 1'b1;
    run_if.run_level  <= lvl;
    run_if.run_length <= len;
    do @(posedge clk_i); while (!run_if.ready);
    tracker.note_run(lvl, len);
    items_sent++;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      run_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.set_reg(idx, val);
  endtask

  // Stop offering and wait for every owed result, then let the pipe empty
  task automatic drain_results();
    run_if.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Close any frame in flight with a run of the wrong level, then drain
  task automatic settle();
    if (tracker.phase != PH_LEAD_MARK) begin
      // expected level is the low phase bit: spaces in odd phases
      send_run(~tracker.phase[0], RUN_LEN_W'(noise_len()));
    end
    drain_results();
  endtask

  // One frame with random content; sometimes corrupted or cut short
  task automatic send_frame();
    logic [TOTAL_BITS-1:0] bits;
    logic lvls[FRAME_RUNS];
    int lens[FRAME_RUNS];
    int tol;
    int bs;
    int bad_pos;
    int stop;
    tol = int'(tracker.tolerance);
    bs  = int'(tracker.bit_space_len);
    case ($urandom_range(9))
      0: bits = '0;
      1: bits = '1;
      default: bits = TOTAL_BITS'($urandom);
    endcase
    lvls[0] = 1'b0;
    lens[0] = draw_len(int'(tracker.lead_mark_len), tol, 1'b0);
    lvls[1] = 1'b1;
    lens[1] = draw_len(int'(tracker.lead_space_len), tol, 1'b0);
    for (int b = 0; b < TOTAL_BITS; b++) begin
      lvls[2 + 2 * b] = 1'b0;
      lens[2 + 2 * b] = draw_len(int'(bits[b] ? tracker.one_mark_len
                                              : tracker.zero_mark_len),
                                 tol, 1'b1);
      lvls[3 + 2 * b] = 1'b1;
      lens[3 + 2 * b] = draw_len(bs, tol, 1'b0);
    end
    // over-long final space: silence runs on after the last bit
    if ($urandom_range(1)) lens[FRAME_RUNS-1] = $urandom_range(65535, bs + tol);
    if ($urandom_range(99) < 20) begin
      bad_pos = $urandom_range(FRAME_RUNS - 1);
      if ($urandom_range(1)) lvls[bad_pos] = ~lvls[bad_pos];
      else lens[bad_pos] = noise_len();
    end
    stop = ($urandom_range(99) < 8) ? $urandom_range(FRAME_RUNS - 1, 1) : FRAME_RUNS;
    for (int i = 0; i < stop; i++) send_run(lvls[i], RUN_LEN_W'(lens[i]));
  endtask

  // Window settings per phase, extremes first
  task automatic program_phase(int p);
    logic [CFG_DATA_W-1:0] v[REG_TOLERANCE+1];
    for (int i = int'(REG_LEADER_MARK); i <= int'(REG_TOLERANCE); i++) begin
      case (p)
        1: v[i] = '0;
        2: v[i] = '1;
        3: v[i] = CFG_DATA_W'($urandom_range(15));
        default: v[i] = CFG_DATA_W'($urandom_range(255));
      endcase
    end
    // upper data bits of the tolerance write are ignored
    if (p == 3) v[REG_TOLERANCE] = {2'($urandom_range(3)), 6'($urandom_range(63, 16))};
    else if (p > 3) v[REG_TOLERANCE] = {2'($urandom_range(3)), 6'($urandom_range(63, 1))};
    for (int i = int'(REG_LEADER_MARK); i <= int'(REG_TOLERANCE); i++)
      write_reg(i[CFG_IDX_W-1:0], v[i]);
    // unused indexes must not disturb any window
    if (p == 1) begin
      for (int i = int'(REG_TOLERANCE) + 1; i < (1 << CFG_IDX_W); i++)
        write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom_range(255)));
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(int p);
    int start_cnt = items_sent;
    src_steady  = (p == 1);
    sink_steady = (p == 1);
    // fill the block against a stalled receiver, then pause for every result
    if (p == 4) begin
      sink_hold  = 250;
      src_steady = 1'b1;
      repeat (40) send_run(1'b1, RUN_LEN_W'(noise_len()));
      src_steady = 1'b0;
      drain_results();
    end
    while (items_sent - start_cnt < PHASE_ITEMS) begin
      if ($urandom_range(99) < 85) send_frame();
      else send_run(1'($urandom_range(1)), RUN_LEN_W'(noise_len()));
    end
  endtask

  // Result receiver with its own stall counters
  initial begin
    int sink_gap;
    sink_gap = 0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        res_if.ready <= 1'b0;
        sink_hold--;
      end else if (sink_gap > 0) begin
        res_if.ready <= 1'b0;
        sink_gap--;
      end else begin
        res_if.ready <= 1'b1;
        if (!sink_steady) sink_gap = pick_gap();
      end
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      tracker.check_result(res_if.status, res_if.command, res_if.address);
  end

  initial begin
    tracker = new();
    rst_ni            <= 1'b0;
    run_if.valid      <= 1'b0;
    run_if.run_level  <= 1'b0;
    run_if.run_length <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed runs at reset windows: edges, wrong levels, each error status
    send_run(1'b0, 16'd0);       // leader mark far too short
    send_run(1'b1, 16'hFFFF);    // space where a leader mark belongs
    send_run(1'b0, 16'd87);      // leader mark at lower edge
    send_run(1'b0, 16'd91);      // mark in place of leader space, dropped
    send_run(1'b1, 16'd23);      // checked as leader mark after the error
    send_run(1'b0, 16'd86);      // just below leader mark window
    send_run(1'b0, 16'd96);      // just above leader mark window
    send_run(1'b0, 16'd95);
    send_run(1'b1, 16'd28);      // leader space just above window
    send_run(1'b0, 16'd91);
    send_run(1'b1, 16'd19);
    send_run(1'b1, 16'd23);      // space where a bit mark belongs
    send_run(1'b0, 16'd91);
    send_run(1'b1, 16'd27);
    send_run(1'b0, 16'd19);      // zero mark on its excluded edge
    send_run(1'b0, 16'd91);
    send_run(1'b1, 16'd23);
    send_run(1'b0, 16'd26);
    send_run(1'b1, 16'd18);      // bit space just below window
    send_run(1'b0, 16'd91);
    send_run(1'b1, 16'd23);
    send_run(1'b0, 16'd49);
    send_run(1'b0, 16'd23);      // mark where a bit space belongs

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p > 0) program_phase(p);
      run_phase(p);
    end
    settle();

    if (tracker.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
